### hdl/tsni_pkg.sv
// Shared types and constants for the TLS ClientHello server-name extractor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tsni_pkg;

  // Item types on the two channels
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic [7:0] name_char;
    logic       char_valid;
    logic       packet_done;
    logic       found;
  } out_item_t;

  // Record and handshake header checks
  localparam logic [7:0]  REC_TYPE_HANDSHAKE  = 8'h16;
  localparam logic [7:0]  REC_VERSION_MAJOR   = 8'h03;
  localparam logic [7:0]  HS_TYPE_CLIENT_HELLO = 8'h01;
  localparam logic [5:0]  OFS_REC_TYPE        = 6'd0;
  localparam logic [5:0]  OFS_VERSION_MAJOR   = 6'd1;
  localparam logic [5:0]  OFS_HS_TYPE         = 6'd5;

  // Header (9) + client version (2) + random (32), counted from zero
  localparam int unsigned HDR_BYTES     = 9;
  localparam int unsigned VERSION_BYTES = 2;
  localparam int unsigned RANDOM_BYTES  = 32;
  localparam logic [5:0]  LAST_FIXED_OFFSET =
    6'(HDR_BYTES + VERSION_BYTES + RANDOM_BYTES - 1);

  // Extension walk
  localparam logic [15:0] EXT_TYPE_SERVER_NAME = 16'h0000;
  localparam logic [15:0] EXT_HDR_BYTES        = 16'd4;
  localparam logic [15:0] SNI_PREFIX_BYTES     = 16'd5;
  localparam logic [2:0]  SNI_LEN_HI_IDX       = 3'd3;
  localparam logic [2:0]  SNI_LEN_LO_IDX       = 3'd4;

endpackage

### hdl/tsni_parser.sv
// Byte-at-a-time ClientHello parser: phase, counters and the per-byte result.
// Depends on tsni_pkg.
`timescale 1ns / 1ps

module tsni_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  tsni_pkg::in_item_t  in_item_i,
  output logic                res_valid_o,
  output tsni_pkg::out_item_t res_o
);
  import tsni_pkg::*;

  typedef enum logic [3:0] {
    PH_HDR,
    PH_SID_LEN,
    PH_SKIP_SID,
    PH_CS_HI,
    PH_CS_LO,
    PH_SKIP_CS,
    PH_CM_LEN,
    PH_SKIP_CM,
    PH_EXT_HI,
    PH_EXT_LO,
    PH_EXT_HDR,
    PH_SKIP_EXT,
    PH_SNI_BODY,
    PH_NAME,
    PH_FOUND,
    PH_IDLE
  } phase_e;

  phase_e      phase_q, phase_d, phase_nxt;
  logic [5:0]  fixed_cnt_q, fixed_cnt_d, fixed_cnt_nxt;
  logic [15:0] skip_q, skip_d, skip_nxt;
  logic [7:0]  len_hi_q, len_hi_d, len_hi_nxt;
  logic [15:0] ext_rem_q, ext_rem_d, ext_rem_nxt;
  logic [15:0] ext_type_q, ext_type_d, ext_type_nxt;
  logic [15:0] ext_len_q, ext_len_d, ext_len_nxt;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d, hdr_cnt_nxt;
  logic [15:0] name_rem_q, name_rem_d, name_rem_nxt;

  logic [7:0]  b;
  logic        eop;
  logic        emit;
  logic [15:0] word;
  logic [15:0] ext_dec;
  logic [15:0] skip_dec;
  logic [15:0] name_dec;
  logic [15:0] sni_skip;

  // Next extension header, or stop when fewer than four declared bytes remain
  function automatic phase_e hdr_or_idle(input logic [15:0] rem);
    return (rem >= EXT_HDR_BYTES) ? PH_EXT_HDR : PH_IDLE;
  endfunction

  function automatic phase_e skip_then_hdr(input logic [15:0] amount,
                                           input logic [15:0] rem);
    phase_e ph;
    if (amount > rem) begin
      ph = PH_IDLE;
    end else if (amount == 16'd0) begin
      ph = hdr_or_idle(rem);
    end else begin
      ph = PH_SKIP_EXT;
    end
    return ph;
  endfunction

  assign b        = in_item_i.data_byte;
  assign eop      = in_item_i.end_of_packet;
  assign word     = {len_hi_q, b};
  assign ext_dec  = ext_rem_q - 16'd1;
  assign skip_dec = skip_q - 16'd1;
  assign name_dec = name_rem_q - 16'd1;
  assign sni_skip = ext_len_q - SNI_PREFIX_BYTES;

  always_comb begin
    phase_nxt     = phase_q;
    fixed_cnt_nxt = fixed_cnt_q;
    skip_nxt      = skip_q;
    len_hi_nxt    = len_hi_q;
    ext_rem_nxt   = ext_rem_q;
    ext_type_nxt  = ext_type_q;
    ext_len_nxt   = ext_len_q;
    hdr_cnt_nxt   = hdr_cnt_q;
    name_rem_nxt  = name_rem_q;
    emit          = 1'b0;

    case (phase_q)
      PH_HDR: begin
        if ((fixed_cnt_q == OFS_REC_TYPE && b != REC_TYPE_HANDSHAKE) ||
            (fixed_cnt_q == OFS_VERSION_MAJOR && b != REC_VERSION_MAJOR) ||
            (fixed_cnt_q == OFS_HS_TYPE && b != HS_TYPE_CLIENT_HELLO)) begin
          phase_nxt = PH_IDLE;
        end else if (fixed_cnt_q >= LAST_FIXED_OFFSET) begin
          phase_nxt = PH_SID_LEN;
        end else begin
          fixed_cnt_nxt = fixed_cnt_q + 6'd1;
        end
      end
      PH_SID_LEN: begin
        skip_nxt  = {8'd0, b};
        phase_nxt = (b == 8'd0) ? PH_CS_HI : PH_SKIP_SID;
      end
      PH_CS_HI: begin
        len_hi_nxt = b;
        phase_nxt  = PH_CS_LO;
      end
      PH_CS_LO: begin
        skip_nxt  = word;
        phase_nxt = (word == 16'd0) ? PH_CM_LEN : PH_SKIP_CS;
      end
      PH_CM_LEN: begin
        skip_nxt  = {8'd0, b};
        phase_nxt = (b == 8'd0) ? PH_EXT_HI : PH_SKIP_CM;
      end
      PH_SKIP_SID, PH_SKIP_CS, PH_SKIP_CM: begin
        skip_nxt = skip_dec;
        if (skip_dec == 16'd0) begin
          case (phase_q)
            PH_SKIP_SID: phase_nxt = PH_CS_HI;
            PH_SKIP_CS:  phase_nxt = PH_CM_LEN;
            default:     phase_nxt = PH_EXT_HI;
          endcase
        end
      end
      PH_EXT_HI: begin
        len_hi_nxt = b;
        phase_nxt  = PH_EXT_LO;
      end
      PH_EXT_LO: begin
        ext_rem_nxt = word;
        hdr_cnt_nxt = 3'd0;
        phase_nxt   = hdr_or_idle(word);
      end
      PH_EXT_HDR: begin
        ext_rem_nxt = ext_dec;
        case (hdr_cnt_q)
          3'd0, 3'd2: begin
            len_hi_nxt  = b;
            hdr_cnt_nxt = hdr_cnt_q + 3'd1;
          end
          3'd1: begin
            ext_type_nxt = word;
            hdr_cnt_nxt  = 3'd2;
          end
          default: begin
            ext_len_nxt = word;
            hdr_cnt_nxt = 3'd0;
            skip_nxt    = word;
            if (ext_type_q == EXT_TYPE_SERVER_NAME && ext_dec >= SNI_PREFIX_BYTES) begin
              phase_nxt = PH_SNI_BODY;
            end else begin
              phase_nxt = skip_then_hdr(word, ext_dec);
            end
          end
        endcase
      end
      PH_SKIP_EXT: begin
        ext_rem_nxt = ext_dec;
        skip_nxt    = skip_dec;
        if (skip_dec == 16'd0) begin
          hdr_cnt_nxt = 3'd0;
          phase_nxt   = hdr_or_idle(ext_dec);
        end
      end
      PH_SNI_BODY: begin
        ext_rem_nxt = ext_dec;
        if (hdr_cnt_q == SNI_LEN_HI_IDX) begin
          len_hi_nxt = b;
        end
        if (hdr_cnt_q < SNI_LEN_LO_IDX) begin
          hdr_cnt_nxt = hdr_cnt_q + 3'd1;
        end else begin
          hdr_cnt_nxt = 3'd0;
          if (word <= ext_dec) begin
            name_rem_nxt = word;
            phase_nxt    = (word == 16'd0) ? PH_FOUND : PH_NAME;
          end else if (ext_len_q >= SNI_PREFIX_BYTES) begin
            // Name does not fit: skip the rest of this extension body
            skip_nxt  = sni_skip;
            phase_nxt = skip_then_hdr(sni_skip, ext_dec);
          end else begin
            phase_nxt = hdr_or_idle(ext_dec);
          end
        end
      end
      PH_NAME: begin
        emit         = 1'b1;
        name_rem_nxt = name_dec;
        if (name_dec == 16'd0) begin
          phase_nxt = PH_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // Drop all parse state at the end of a packet
  always_comb begin
    if (eop) begin
      phase_d     = PH_HDR;
      fixed_cnt_d = '0;
      skip_d      = '0;
      len_hi_d    = '0;
      ext_rem_d   = '0;
      ext_type_d  = '0;
      ext_len_d   = '0;
      hdr_cnt_d   = '0;
      name_rem_d  = '0;
    end else begin
      phase_d     = phase_nxt;
      fixed_cnt_d = fixed_cnt_nxt;
      skip_d      = skip_nxt;
      len_hi_d    = len_hi_nxt;
      ext_rem_d   = ext_rem_nxt;
      ext_type_d  = ext_type_nxt;
      ext_len_d   = ext_len_nxt;
      hdr_cnt_d   = hdr_cnt_nxt;
      name_rem_d  = name_rem_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HDR;
      fixed_cnt_q <= '0;
      skip_q      <= '0;
      len_hi_q    <= '0;
      ext_rem_q   <= '0;
      ext_type_q  <= '0;
      ext_len_q   <= '0;
      hdr_cnt_q   <= '0;
      name_rem_q  <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      fixed_cnt_q <= fixed_cnt_d;
      skip_q      <= skip_d;
      len_hi_q    <= len_hi_d;
      ext_rem_q   <= ext_rem_d;
      ext_type_q  <= ext_type_d;
      ext_len_q   <= ext_len_d;
      hdr_cnt_q   <= hdr_cnt_d;
      name_rem_q  <= name_rem_d;
    end
  end

  assign res_valid_o       = accept_i && (emit || eop);
  assign res_o.name_char   = emit ? b : 8'd0;
  assign res_o.char_valid  = emit;
  assign res_o.packet_done = eop;
  assign res_o.found       = eop && (phase_nxt == PH_FOUND);

endmodule

### hdl/tsni_out_buf.sv
// Two-entry result buffer (output register plus skid) for the result channel.
// Depends on tsni_pkg.
`timescale 1ns / 1ps

module tsni_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  input  tsni_pkg::out_item_t res_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tsni_pkg::out_item_t out_item_o
);
  import tsni_pkg::*;

  logic      main_valid_q;
  logic      skid_valid_q;
  out_item_t main_q;
  out_item_t skid_q;
  logic      main_free;

  assign main_free = !main_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (main_free) begin
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= res_valid_i;
      end else begin
        main_valid_q <= res_valid_i;
      end
    end else if (res_valid_i) begin
      // Output stalled: park the new request in the skid entry
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_free) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
        skid_q <= res_i;
      end else begin
        main_q <= res_i;
      end
    end else if (res_valid_i) begin
      skid_q <= res_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_item_o  = main_q;

endmodule

### hdl/tls_sni_extractor.sv
// TLS ClientHello server-name extractor, top level.
// Depends on tsni_pkg, tsni_parser and tsni_out_buf.
//
// Usage:
//   Feed the TCP payload one byte per request on the input channel
//   (in_valid_i / in_stall_o / in_item_i), with end_of_packet set on the
//   packet's final byte. A request is taken at a clock edge with valid high
//   and stall low.
//   The result channel (out_valid_o / out_stall_i / out_item_o) carries one
//   request per server-name byte (char_valid=1) and exactly one request per
//   packet with packet_done=1, which may also carry the last name byte.
//   found=1 on that request means the whole name went out; found=0 means no
//   name, or a truncated one that downstream must discard.
//   Bytes that produce no result leave nothing on the result channel.
// Timing:
//   One byte per clock sustained while in_stall_o is low. A result is
//   registered in the result buffer at the edge that takes its byte, as is the parse state.
//   A two-entry result buffer lets input flow while a result waits; in_stall_o
//   rises only when both entries hold results that out_stall_i keeps back.
// Reset:
//   rst_ni clears the parse state to the record-header phase and empties the
//   result buffer; the block takes input as soon as reset is released.
`timescale 1ns / 1ps

module tls_sni_extractor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tsni_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tsni_pkg::out_item_t out_item_o
);
  import tsni_pkg::*;

  logic      accept;
  logic      res_valid;
  logic      buf_full;
  out_item_t res;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  tsni_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_item_i  (in_item_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  tsni_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

### hdl/tsni_checker.sv
// Port-level checks for tls_sni_extractor, attached by the bind below.
// Depends on tsni_pkg.
`timescale 1ns / 1ps

module tsni_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input tsni_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tsni_pkg::out_item_t out_item_o
);
  import tsni_pkg::*;

  // Every result carries a name byte or closes a packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.char_valid || out_item_o.packet_done))
    else $error("empty result request");

  // found only on the closing request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.found) |-> out_item_o.packet_done)
    else $error("found without packet_done");

  // Input backs up only while a result is held on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && $past(out_valid_o && out_stall_i)))
    else $error("input stalled with no result held");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

  // A taken end-of-packet byte, with the output empty, yields a closing request in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_item_i.end_of_packet && !out_valid_o)
      |=> (out_valid_o && out_item_o.packet_done))
    else $error("missing packet_done result");

endmodule

bind tls_sni_extractor tsni_checker u_tsni_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);
